[hw/rtl/sorted_table_binary_search_top_assert.svh]
// Assertion macros for the sorted table blocks.
// Used by modules that include this header; expects i_clk and i_rst_n in scope.
`ifndef SORTED_TABLE_BINARY_SEARCH_TOP_ASSERT_SVH
`define SORTED_TABLE_BINARY_SEARCH_TOP_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define STBS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante.
`define STBS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/stbs_pkg.sv]
// Shared types and constants for the sorted table with binary search.
// No dependencies; imported by the controller, the datapath and the top level.
`timescale 1ns / 1ps

package stbs_pkg;

    // Table geometry.
    localparam int TABLE_DEPTH = 256;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    // Item field widths.
    localparam int VAL_W       = 32;
    localparam int REQ_W       = 2;
    localparam int COUNT_OUT_W = 9;
    localparam int OUT_DATA_W  = 16;

    // Request codes.
    localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_INSERT = 2'd1;
    localparam logic [REQ_W-1:0] REQ_SEARCH = 2'd2;

    // Controller states.
    typedef enum logic [5:0] {
        ST_IDLE     = 6'b000001,
        ST_INS_RD   = 6'b000010,
        ST_INS_CMP  = 6'b000100,
        ST_SRCH_RD  = 6'b001000,
        ST_SRCH_CMP = 6'b010000,
        ST_DONE     = 6'b100000
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;        // capture a new item
        logic clear;       // empty the table on load
        logic flag_full;   // mark the insert as dropped on load
        logic rd_ins;      // read the entry below the insert position
        logic rd_next;     // read two below the insert position while shifting
        logic shift;       // move the read entry up into the insert position
        logic place;       // write the new value at the insert position
        logic rd_probe;    // read the middle of the search range
        logic probe_step;  // narrow the search range
        logic set_found;   // mark the search as a hit
        logic out_load;    // move the result into the output register
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic full;        // table holds TABLE_DEPTH entries
        logic pos_zero;    // insert position is at the bottom
        logic pos_one;     // insert position is one above the bottom
        logic gt;          // read entry is greater than the item value
        logic eq;          // read entry equals the item value
        logic range_empty; // search range holds nothing
    } t_stat;

endpackage

[hw/rtl/stbs_ctrl.sv]
// Controller state machine for the sorted table: sequences clear, insert and search.
// Depends on stbs_pkg; drives the datapath only through t_cmd and reads t_stat.
`timescale 1ns / 1ps

module stbs_ctrl
    import stbs_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic [REQ_W-1:0] i_req_type,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    input  t_stat            i_stat,
    output t_cmd             o_cmd
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    t_cmd   w_cmd;

    // Next state and command decode.
    always_comb begin
        n_state = r_state;
        w_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    w_cmd.load      = 1'b1;
                    w_cmd.clear     = (i_req_type == REQ_CLEAR);
                    w_cmd.flag_full = (i_req_type == REQ_INSERT) && i_stat.full;
                    if (i_req_type == REQ_INSERT && !i_stat.full) begin
                        n_state = ST_INS_RD;
                    end else if (i_req_type == REQ_SEARCH) begin
                        n_state = ST_SRCH_RD;
                    end else begin
                        n_state = ST_DONE;
                    end
                end
            end
            ST_INS_RD: begin
                if (i_stat.pos_zero) begin
                    w_cmd.place = 1'b1;
                    n_state     = ST_DONE;
                end else begin
                    w_cmd.rd_ins = 1'b1;
                    n_state      = ST_INS_CMP;
                end
            end
            ST_INS_CMP: begin
                if (i_stat.gt) begin
                    w_cmd.shift = 1'b1;
                    if (i_stat.pos_one) begin
                        n_state = ST_INS_RD;
                    end else begin
                        w_cmd.rd_next = 1'b1;
                    end
                end else begin
                    w_cmd.place = 1'b1;
                    n_state     = ST_DONE;
                end
            end
            ST_SRCH_RD: begin
                if (i_stat.range_empty) begin
                    n_state = ST_DONE;
                end else begin
                    w_cmd.rd_probe = 1'b1;
                    n_state        = ST_SRCH_CMP;
                end
            end
            ST_SRCH_CMP: begin
                if (i_stat.eq) begin
                    w_cmd.set_found = 1'b1;
                    n_state         = ST_DONE;
                end else begin
                    w_cmd.probe_step = 1'b1;
                    n_state          = ST_SRCH_RD;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    w_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Output register valid flag.
    always_comb begin
        n_out_valid = r_out_valid;
        if (w_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = w_cmd;

endmodule

[hw/rtl/stbs_dp.sv]
// Datapath for the sorted table: entry memory, count, insert position and search range.
// Depends on stbs_pkg and the assertion macro header; commanded by stbs_ctrl.
`timescale 1ns / 1ps
`include "sorted_table_binary_search_top_assert.svh"

module stbs_dp
    import stbs_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic [VAL_W-1:0]       i_value,
    input  t_cmd                   i_cmd,
    output t_stat                  o_stat,
    output logic                   o_found,
    output logic                   o_status,
    output logic [COUNT_OUT_W-1:0] o_entry_count
);

    // Entry memory, one write and one read port, registered read data.
    logic [VAL_W-1:0] r_mem [TABLE_DEPTH];
    logic [VAL_W-1:0] r_rd_data;

    logic [CNT_W-1:0] r_count, n_count;
    logic [VAL_W-1:0] r_key;
    logic [CNT_W-1:0] r_pos;
    logic [CNT_W-1:0] r_lo;
    logic [CNT_W-1:0] r_hi;
    logic             r_found;
    logic             r_status;

    logic                   r_out_found;
    logic                   r_out_status;
    logic [COUNT_OUT_W-1:0] r_out_count;

    logic [CNT_W-1:0] w_mid;
    logic [CNT_W-1:0] w_rd_ptr;
    logic             w_rd_en;
    logic             w_wr_en;
    logic [VAL_W-1:0] w_wr_data;
    t_stat            w_stat;

    // Middle of the half-open search range.
    assign w_mid = r_lo + ((r_hi - r_lo) >> 1);

    // Read address select.
    always_comb begin
        priority if (i_cmd.rd_ins) begin
            w_rd_ptr = r_pos - CNT_W'(1);
        end else if (i_cmd.rd_next) begin
            w_rd_ptr = r_pos - CNT_W'(2);
        end else begin
            w_rd_ptr = w_mid;
        end
    end

    assign w_rd_en   = i_cmd.rd_ins | i_cmd.rd_next | i_cmd.rd_probe;
    assign w_wr_en   = i_cmd.shift | i_cmd.place;
    assign w_wr_data = i_cmd.shift ? r_rd_data : r_key;

    // Memory access; the write always targets the insert position.
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[r_pos[IDX_W-1:0]] <= w_wr_data;
        end
        if (w_rd_en) begin
            r_rd_data <= r_mem[w_rd_ptr[IDX_W-1:0]];
        end
    end

    // Entry count.
    always_comb begin
        n_count = r_count;
        if (i_cmd.load && i_cmd.clear) begin
            n_count = '0;
        end else if (i_cmd.place) begin
            n_count = r_count + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // Per-item working registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_key    <= i_value;
            r_pos    <= r_count;
            r_lo     <= '0;
            r_hi     <= r_count;
            r_found  <= 1'b0;
            r_status <= i_cmd.flag_full;
        end else begin
            if (i_cmd.shift) begin
                r_pos <= r_pos - CNT_W'(1);
            end
            if (i_cmd.probe_step) begin
                if (w_stat.gt) begin
                    r_hi <= w_mid;
                end else begin
                    r_lo <= w_mid + CNT_W'(1);
                end
            end
            if (i_cmd.set_found) begin
                r_found <= 1'b1;
            end
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_found  <= r_found;
            r_out_status <= r_status;
            r_out_count  <= COUNT_OUT_W'(r_count);
        end
    end

    // Status toward the controller; the greater-than compare of values is signed.
    always_comb begin
        w_stat.full        = (r_count >= CNT_W'(TABLE_DEPTH));
        w_stat.pos_zero    = (r_pos == '0);
        w_stat.pos_one     = (r_pos == CNT_W'(1));
        w_stat.gt          = ($signed(r_rd_data) > $signed(r_key));
        w_stat.eq          = (r_rd_data == r_key);
        w_stat.range_empty = (r_lo >= r_hi);
    end

    assign o_stat        = w_stat;
    assign o_found       = r_out_found;
    assign o_status      = r_out_status;
    assign o_entry_count = r_out_count;

    // The count never passes the table depth.
    `STBS_ASSERT_NOW(a_count_bound, 1'b1, r_count <= CNT_W'(TABLE_DEPTH), "count above depth")
    // A value is only placed when the table has room.
    `STBS_ASSERT_NOW(a_place_room, i_cmd.place, !w_stat.full, "place into full table")
    // An entry only moves up when it is larger and not at the bottom.
    `STBS_ASSERT_NOW(a_shift_order, i_cmd.shift, w_stat.gt && !w_stat.pos_zero, "bad shift")
    // Placing a value grows the count by one.
    `STBS_ASSERT_NEXT(a_place_grows, i_cmd.place, r_count == $past(r_count) + CNT_W'(1),
        "count did not grow")

endmodule

[hw/rtl/sorted_table_binary_search_top.sv]
// Top level of the sorted table with binary search: stream ports around controller and datapath.
// Depends on stbs_pkg, stbs_ctrl and stbs_dp.
`timescale 1ns / 1ps

// The block keeps up to 256 signed 32-bit values in ascending order and takes one
// request per item: clear, insert or search, selected by s_axis_tuser. Each item gives
// exactly one result with found, the dropped-insert flag and the entry count. Work is
// one item at a time over a single-port-write, single-port-read entry memory. An insert
// moves each larger entry up one place per cycle through the memory, then writes the
// new value; a full-table insert is dropped. A search reads the middle entry of its
// range and then compares it, once for each probe. The result sits in an output
// register, so the next item is accepted while the previous result waits to be
// taken.

module sorted_table_binary_search_top
    import stbs_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [VAL_W-1:0]      s_axis_tdata,  // [31:0] value
    input  logic [REQ_W-1:0]      s_axis_tuser,  // [1:0] req_type
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata   // [0] found, [1] status, [10:2] entry_count
);

    t_cmd                   w_cmd;
    t_stat                  w_stat;
    logic                   w_found;
    logic                   w_status;
    logic [COUNT_OUT_W-1:0] w_entry_count;

    // Request sequencing.
    stbs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_req_type  (s_axis_tuser),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    // Table storage and compare logic.
    stbs_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_value       (s_axis_tdata),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .o_found       (w_found),
        .o_status      (w_status),
        .o_entry_count (w_entry_count)
    );

    // Pack the result fields, lowest first, zero filled to whole bytes.
    assign m_axis_tdata = {(OUT_DATA_W - COUNT_OUT_W - 2)'(0), w_entry_count, w_status, w_found};

endmodule

[dv/tb.sv]
// Self-checking testbench for the sorted table with binary search (clear, insert, search).
// Depends on stbs_pkg and sorted_table_binary_search_top; predicts every result in-house.
`timescale 1ns / 1ps

module tb;
    import stbs_pkg::*;

    // Request code that the block must ignore.
    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
    localparam int ITEMS_TOTAL   = 650;
    localparam int IDLE_PCT      = 23;
    localparam int HOLD_CYCLES   = 400;
    localparam int STALL_LIMIT   = 5000;
    localparam int DRAIN_CYCLES  = 300;
    localparam int DIRECTED_ROWS = 20;

    // One result item as the block reports it.
    typedef struct packed {
        logic                   found;
        logic                   status;
        logic [COUNT_OUT_W-1:0] entry_count;
    } t_outcome;

    // One row of the directed stimulus; typed rows carry their own expectation.
    typedef struct packed {
        logic [REQ_W-1:0]       req;
        logic [VAL_W-1:0]       value;
        logic                   typed;
        logic                   exp_found;
        logic                   exp_status;
        logic [COUNT_OUT_W-1:0] exp_count;
    } t_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [VAL_W-1:0]      s_axis_tdata;   // [31:0] value
    logic [REQ_W-1:0]      s_axis_tuser;   // [1:0] req_type
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;   // [0] found, [1] status, [10:2] entry_count

    // Shadow copy of the table used for prediction.
    logic signed [VAL_W-1:0] held_vals [TABLE_DEPTH];
    int                      held_n;

    t_outcome pending_results [$];
    int       mismatches;
    int       items_sent;
    int       idle_cycles;
    int       hold_asks;
    int       hold_done;
    int       hold_left;
    bit       calm;

    t_row directed_rows [DIRECTED_ROWS] = '{
        '{REQ_SEARCH, 32'h0000_0000, 1'b1, 1'b0, 1'b0, 9'd0},
        '{REQ_INSERT, 32'h7FFF_FFFF, 1'b1, 1'b0, 1'b0, 9'd1},
        '{REQ_INSERT, 32'h8000_0000, 1'b1, 1'b0, 1'b0, 9'd2},
        '{REQ_INSERT, 32'h0000_0000, 1'b1, 1'b0, 1'b0, 9'd3},
        '{REQ_SEARCH, 32'h8000_0000, 1'b1, 1'b1, 1'b0, 9'd3},
        '{REQ_SEARCH, 32'h7FFF_FFFF, 1'b1, 1'b1, 1'b0, 9'd3},
        '{REQ_SEARCH, 32'h0000_0000, 1'b1, 1'b1, 1'b0, 9'd3},
        '{REQ_SEARCH, 32'h0000_0001, 1'b1, 1'b0, 1'b0, 9'd3},
        '{REQ_SEARCH, 32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0, 9'd3},
        '{REQ_INSERT, 32'h0000_0000, 1'b1, 1'b0, 1'b0, 9'd4},
        '{REQ_INSERT, 32'hFFFF_FFFB, 1'b0, 1'b0, 1'b0, 9'd0},
        '{REQ_INSERT, 32'h0000_3039, 1'b0, 1'b0, 1'b0, 9'd0},
        '{REQ_SEARCH, 32'hFFFF_FFFB, 1'b0, 1'b0, 1'b0, 9'd0},
        '{REQ_UNUSED, 32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0, 9'd6},
        '{REQ_CLEAR,  32'h0000_0000, 1'b1, 1'b0, 1'b0, 9'd0},
        '{REQ_SEARCH, 32'h0000_0000, 1'b1, 1'b0, 1'b0, 9'd0},
        '{REQ_INSERT, 32'hAAAA_AAAA, 1'b0, 1'b0, 1'b0, 9'd0},
        '{REQ_INSERT, 32'h5555_5555, 1'b0, 1'b0, 1'b0, 9'd0},
        '{REQ_SEARCH, 32'hAAAA_AAAA, 1'b0, 1'b0, 1'b0, 9'd0},
        '{REQ_UNUSED, 32'h0000_0000, 1'b0, 1'b0, 1'b0, 9'd0}
    };

    sorted_table_binary_search_top u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Clock with a 10 ns period.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Apply one request to the shadow table and return the result it should give.
    function automatic t_outcome apply_request(input logic [REQ_W-1:0] req,
                                               input logic signed [VAL_W-1:0] val);
        t_outcome res;
        int       pos;
        int       lo;
        int       hi;
        int       mid;
        res = '0;
        case (req)
            REQ_CLEAR: begin
                held_n = 0;
            end
            REQ_INSERT: begin
                if (held_n >= TABLE_DEPTH) begin
                    res.status = 1'b1;
                end else begin
                    // Larger entries move up; equal ones stay below the new value.
                    pos = held_n;
                    while (pos > 0 && held_vals[pos-1] > val) begin
                        held_vals[pos] = held_vals[pos-1];
                        pos--;
                    end
                    held_vals[pos] = val;
                    held_n++;
                end
            end
            REQ_SEARCH: begin
                lo = 0;
                hi = held_n;
                while (lo < hi) begin
                    mid = lo + (hi - lo) / 2;
                    if (held_vals[mid] == val) begin
                        res.found = 1'b1;
                        break;
                    end
                    if (held_vals[mid] > val) begin
                        hi = mid;
                    end else begin
                        lo = mid + 1;
                    end
                end
            end
            default: ;
        endcase
        res.entry_count = held_n[COUNT_OUT_W-1:0];
        return res;
    endfunction

    // Offer one request item, wait for it to be taken, and queue its expected result.
    task automatic offer(input logic [REQ_W-1:0] req, input logic [VAL_W-1:0] val,
                         input bit typed, input t_outcome typed_res);
        t_outcome res;
        @(negedge i_clk);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = val;
        s_axis_tuser  = req;
        do @(posedge i_clk); while (!s_axis_tready);
        res = apply_request(req, val);
        pending_results.push_back(typed ? typed_res : res);
        items_sent++;
    endtask

    // Hold the input idle until every queued result has come out.
    task automatic drain();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // Insert values: extremes, a narrow band that repeats often, and full-range values.
    function automatic logic [VAL_W-1:0] pick_insert_value();
        case ($urandom_range(0, 9))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2, 3, 4: return $unsigned($signed($urandom_range(0, 40)) - 20);
            default: return $urandom;
        endcase
    endfunction

    // Search values: mostly held entries and their neighbors, some arbitrary values.
    function automatic logic [VAL_W-1:0] pick_search_value();
        logic [VAL_W-1:0] v;
        if (held_n == 0 || $urandom_range(0, 99) < 25) begin
            v = ($urandom_range(0, 1) != 0) ? $urandom : pick_insert_value();
        end else begin
            v = held_vals[$urandom_range(0, held_n - 1)];
            case ($urandom_range(0, 5))
                0:       v = v + 1;
                1:       v = v - 1;
                default: ;
            endcase
        end
        return v;
    endfunction

    // Result side: random stalls, a long hold-off on request, steady when calm.
    always @(negedge i_clk) begin
        if (hold_asks != hold_done) begin
            hold_done = hold_asks;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready = 1'b0;
        end else if (calm) begin
            m_axis_tready = 1'b1;
        end else begin
            m_axis_tready = ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // Compare each result item with the oldest expectation.
    always @(posedge i_clk) begin
        t_outcome want;
        t_outcome got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.found       = m_axis_tdata[0];
            got.status      = m_axis_tdata[1];
            got.entry_count = m_axis_tdata[10:2];
            if (pending_results.size() == 0) begin
                $error("unexpected result item: tdata=%h", m_axis_tdata);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                if (got.found !== want.found) begin
                    $error("found: expected %0d, actual %0d", want.found, got.found);
                    mismatches++;
                end
                if (got.status !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, got.status);
                    mismatches++;
                end
                if (got.entry_count !== want.entry_count) begin
                    $error("entry_count: expected %0d, actual %0d",
                           want.entry_count, got.entry_count);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog on cycles in which neither side moves an item.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Stimulus: directed rows, then phases of random requests.
    initial begin
        t_outcome typed_res;
        int       phase;
        int       n;
        int       r;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = REQ_CLEAR;
        m_axis_tready = 1'b0;
        held_n        = 0;
        mismatches    = 0;
        items_sent    = 0;
        idle_cycles   = 0;
        hold_asks     = 0;
        hold_done     = 0;
        hold_left     = 0;
        calm          = 1'b0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part: extremes, duplicates, misses, empty table and the unused code.
        foreach (directed_rows[i]) begin
            typed_res.found       = directed_rows[i].exp_found;
            typed_res.status      = directed_rows[i].exp_status;
            typed_res.entry_count = directed_rows[i].exp_count;
            offer(directed_rows[i].req, directed_rows[i].value, directed_rows[i].typed,
                  typed_res);
        end

        // Random phases; a few of them apply pressure or fill the table.
        phase = 0;
        while (items_sent < ITEMS_TOTAL) begin
            calm = (phase == 1);
            if (phase == 2) begin
                hold_asks++;
            end
            if (phase == 3 || phase == 6) begin
                drain();
            end
            if (phase == 4) begin
                // Fill to the top, then try a few inserts that must be dropped.
                offer(REQ_CLEAR, $urandom, 1'b0, '0);
                for (int k = 0; k < TABLE_DEPTH + 4; k++) begin
                    offer(REQ_INSERT, pick_insert_value(), 1'b0, '0);
                end
                for (int k = 0; k < 20; k++) begin
                    offer(REQ_SEARCH, pick_search_value(), 1'b0, '0);
                end
            end else begin
                if ($urandom_range(0, 1) != 0) begin
                    offer(REQ_CLEAR, $urandom, 1'b0, '0);
                end
                n = $urandom_range(20, 60);
                for (int k = 0; k < n; k++) begin
                    r = $urandom_range(0, 99);
                    if (r < 48) begin
                        offer(REQ_INSERT, pick_insert_value(), 1'b0, '0);
                    end else if (r < 90) begin
                        offer(REQ_SEARCH, pick_search_value(), 1'b0, '0);
                    end else if (r < 94) begin
                        offer(REQ_CLEAR, $urandom, 1'b0, '0);
                    end else begin
                        offer(REQ_UNUSED, $urandom, 1'b0, '0);
                    end
                end
            end
            phase++;
        end
        calm = 1'b0;

        // Let the last results out, then watch for stray items.
        drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            $error("%0d expected results never arrived", pending_results.size());
            mismatches++;
        end
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/stbs_pkg.sv
hw/rtl/stbs_ctrl.sv
hw/rtl/stbs_dp.sv
hw/rtl/sorted_table_binary_search_top.sv
dv/tb.sv
